@@ rtl/mpsm_pkg.sv @@
// shared types and constants for the streaming morris-pratt matcher
// no dependencies
package mpsm_pkg;

    localparam int MAX_PATTERN_DEF = 256;

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_APPEND  = 2'd1,
        FUNC_TEXT    = 2'd2,
        FUNC_RESTART = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FAIL,
        ST_LAST,
        ST_OUT
    } state_t;

endpackage

@@ rtl/morris_pratt_stream_matcher_top.sv @@
// streaming morris-pratt matcher: a queue of up to two beats feeds the engine
// clear and restart go from idle to the result; text on an empty pattern or
// a refused append passes read first; other beats pass read, a compare step
// per byte compare, a fail step per link followed and the last step; no beat
// is taken until the result is; links amortise to two compares
// asynchronous active-low reset empties the pattern and restarts the text
module morris_pratt_stream_matcher_top
    import mpsm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        match_found,
    output logic [31:0] match_start,
    output logic [31:0] match_total,
    output logic        load_rejected
);

    logic       q_valid;
    logic       q_ready;
    logic [1:0] q_func;
    logic [7:0] q_byte;

    // front queue
    mpsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_func   (func),
        .in_byte   (byte_value),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_func  (q_func),
        .out_byte  (q_byte)
    );

    // back engine
    mpsm_engine #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (q_valid),
        .cmd_ready     (q_ready),
        .cmd_func      (q_func),
        .cmd_byte      (q_byte),
        .res_valid     (out_valid),
        .res_ready     (out_ready),
        .match_found   (match_found),
        .match_start   (match_start),
        .match_total   (match_total),
        .load_rejected (load_rejected)
    );

endmodule

@@ rtl/mpsm_queue.sv @@
// two-entry queue between the front part and the execution engine
// depends on mpsm_pkg
module mpsm_queue
    import mpsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_func,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_func,
    output logic [7:0] out_byte
);

    logic [9:0] mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_func  = mem_reg[rp_reg][9:8];
    assign out_byte  = mem_reg[rp_reg][7:0];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= {in_func, in_byte};
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/mpsm_engine.sv @@
// execution engine: pattern/failure memories, link walks and counters
// depends on mpsm_pkg
module mpsm_engine
    import mpsm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  cmd_func,
    input  logic [7:0]  cmd_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        match_found,
    output logic [31:0] match_start,
    output logic [31:0] match_total,
    output logic        load_rejected
);

    localparam int AW = $clog2(MAX_PATTERN + 1);
    localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    // signed index: -1 .. MAX_PATTERN
    localparam int IW = AW + 1;
    localparam logic [IW-1:0] NEG1 = '1;

    // memories
    logic [7:0]    pat_mem [MAX_PATTERN];
    logic [IW-1:0] fail_mem [MAX_PATTERN + 1];
    logic [7:0]    pat_rd_reg;
    logic [IW-1:0] fail_rd_reg;

    state_t        state_reg, state_next;
    logic [1:0]    func_reg;
    logic [7:0]    byte_reg;
    logic [AW-1:0] cnt_reg;
    logic [IW-1:0] border_reg;
    logic [IW-1:0] mlen_reg;
    logic [IW-1:0] j_reg, j_next;
    logic [31:0]   pos_reg;
    logic [31:0]   occ_reg;
    logic          found_reg;
    logic [31:0]   start_reg;
    logic          rej_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_pat;
    logic          wr_fail;
    logic [AW-1:0] wr_fail_addr;
    logic [IW-1:0] wr_fail_data;
    logic          full;
    logic          j_neg;
    logic          j_inr;
    logic          eq;
    logic [7:0]    cmp_byte;
    logic [IW-1:0] jp1;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign full      = (cnt_reg == AW'(MAX_PATTERN));
    assign j_neg     = j_reg[IW-1];
    assign j_inr     = !j_neg && (j_reg[AW-1:0] < cnt_reg);
    assign cmp_byte  = byte_reg;
    assign eq        = (pat_rd_reg == cmp_byte);
    assign jp1       = j_reg + IW'(1);
    assign rd_addr   = j_reg[AW-1:0];

    // memory ports: one read address per cycle, registered data
    always_ff @(posedge clk)
    begin
        if (wr_pat)
        begin
            pat_mem[cnt_reg[PW-1:0]] <= byte_reg;
        end
        if (wr_fail)
        begin
            fail_mem[wr_fail_addr] <= wr_fail_data;
        end
        if (rd_en)
        begin
            pat_rd_reg  <= pat_mem[rd_addr[PW-1:0]];
            fail_rd_reg <= fail_mem[rd_addr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_func == FUNC_APPEND || cmd_func == FUNC_TEXT)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_READ:
            begin
                if (func_reg == FUNC_APPEND && full)
                begin
                    state_next = ST_OUT;
                end
                else if (func_reg == FUNC_TEXT && cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else if (j_inr)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_LAST;
                end
            end
            ST_CMP:
            begin
                if (eq)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    state_next = ST_FAIL;
                end
            end
            ST_FAIL:
            begin
                if (j_inr)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read enable and walk index
    always_comb
    begin
        rd_en  = 1'b0;
        j_next = j_reg;
        case (state_reg)
            ST_READ:
            begin
                rd_en = j_inr;
            end
            ST_CMP:
            begin
                // entry zero of the failure table is minus one; the walk uses that value directly
                if (!eq)
                begin
                    j_next = (j_reg == '0) ? NEG1 : fail_rd_reg;
                end
            end
            ST_FAIL:
            begin
                rd_en = j_inr;
            end
            ST_LAST:
            begin
                // no read: the entry at the full length is kept in a register
                rd_en = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // write ports
    always_comb
    begin
        wr_pat       = 1'b0;
        wr_fail      = 1'b0;
        wr_fail_addr = cnt_reg + AW'(1);
        wr_fail_data = jp1;
        if (state_reg == ST_READ && func_reg == FUNC_APPEND && !full)
        begin
            wr_pat = 1'b1;
        end
        if (state_reg == ST_LAST && func_reg == FUNC_APPEND)
        begin
            wr_fail = 1'b1;
        end
        if (state_reg == ST_IDLE && cmd_valid && cmd_func == FUNC_CLEAR)
        begin
            wr_fail      = 1'b1;
            wr_fail_addr = '0;
            wr_fail_data = NEG1;
        end
    end

    // failure entry at the full pattern length, kept alongside the memory
    logic [IW-1:0] fail_top_reg;

    // control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            border_reg   <= NEG1;
            mlen_reg     <= '0;
            pos_reg      <= '0;
            occ_reg      <= '0;
            fail_top_reg <= NEG1;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd_func == FUNC_CLEAR)
                        begin
                            cnt_reg      <= '0;
                            border_reg   <= NEG1;
                            fail_top_reg <= NEG1;
                            mlen_reg     <= '0;
                            pos_reg      <= '0;
                            occ_reg      <= '0;
                        end
                        else if (cmd_func == FUNC_RESTART)
                        begin
                            mlen_reg <= '0;
                            pos_reg  <= '0;
                            occ_reg  <= '0;
                        end
                    end
                end
                ST_READ:
                begin
                    if (func_reg == FUNC_TEXT)
                    begin
                        pos_reg <= pos_reg + 32'd1;
                        if (cnt_reg == '0)
                        begin
                            mlen_reg <= '0;
                        end
                    end
                end
                ST_LAST:
                begin
                    if (func_reg == FUNC_APPEND)
                    begin
                        cnt_reg      <= cnt_reg + AW'(1);
                        border_reg   <= jp1;
                        fail_top_reg <= jp1;
                    end
                    else if (jp1[AW-1:0] >= cnt_reg && !jp1[IW-1])
                    begin
                        if (occ_reg != '1)
                        begin
                            occ_reg <= occ_reg + 32'd1;
                        end
                        mlen_reg <= fail_top_reg;
                    end
                    else
                    begin
                        mlen_reg <= jp1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    func_reg  <= cmd_func;
                    byte_reg  <= cmd_byte;
                    found_reg <= 1'b0;
                    start_reg <= '0;
                    rej_reg   <= 1'b0;
                    j_reg     <= (cmd_func == FUNC_APPEND) ? border_reg : mlen_reg;
                end
            end
            ST_READ:
            begin
                if (func_reg == FUNC_APPEND)
                begin
                    rej_reg <= full;
                end
            end
            ST_LAST:
            begin
                if (func_reg == FUNC_TEXT && !jp1[IW-1] && jp1[AW-1:0] >= cnt_reg)
                begin
                    found_reg <= 1'b1;
                    start_reg <= pos_reg - 32'(cnt_reg);
                end
            end
            default:
            begin
                j_reg <= j_next;
            end
        endcase
    end

    // result fields
    assign match_found   = found_reg;
    assign match_start   = start_reg;
    assign match_total   = (func_reg == FUNC_TEXT) ? occ_reg : 32'd0;
    assign load_rejected = rej_reg;

endmodule
